// ===== rtl/barometer_compensation_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Barometer compensation assertion macros
// Shared concurrent assertion forms for the barometer compensation checks.
// ----------------------------------------------------------------------------
`ifndef BAROMETER_COMPENSATION_UNIT_MACROS_SVH
`define BAROMETER_COMPENSATION_UNIT_MACROS_SVH

// clocked, reset-gated assertion
`define BCU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("barometer compensation check failed");

// assertion on the block clock and reset
`define BCU_CHECK(lbl, prop) \
  `BCU_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Register map, operation codes and compensation constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bcu_pkg;

  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  localparam logic [2:0] REG_AC123 = 3'd0;
  localparam logic [2:0] REG_AC456 = 3'd1;
  localparam logic [2:0] REG_B12   = 3'd2;
  localparam logic [2:0] REG_MCMD  = 3'd3;
  localparam logic [2:0] REG_OSS   = 3'd4;

  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] P_C1      = 32'd3038;
  localparam logic [31:0] P_C2_NEG  = 32'hFFFF_E343;
  localparam logic [31:0] P_C3      = 32'd3791;
  localparam logic [31:0] P_SCALE   = 32'd50000;
  localparam logic [31:0] P_HALF    = 32'h8000_0000;

endpackage
`default_nettype wire

// ===== rtl/barometer_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation unit
// Turns raw temperature and pressure readings into 0.1 C and pascal values.
// ----------------------------------------------------------------------------
// One item at a time, computed with a 32-step radix-2 divider and a single
// 32x32 multiplier shared by all product terms. in_ready_o is high only while
// the sequencer is idle; a finished result sits in the output register and the
// next item is taken meanwhile. Calibration registers sit on an APB port at
// byte address 8*i and must be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module barometer_compensation_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bcu_pkg::AddrW-1:0] paddr,
  input  wire logic [bcu_pkg::DataW-1:0] pwdata,
  output logic      [bcu_pkg::DataW-1:0] prdata,
  output logic                           pready,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      operation_i,
  input  wire logic [23:0]               raw_reading_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           result_kind_o,
  output logic signed [31:0]             compensated_value_o,
  output logic                           divide_fault_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_T_MUL = 5'd1;
  localparam logic [4:0] S_T_X1  = 5'd2;
  localparam logic [4:0] S_T_CHK = 5'd3;
  localparam logic [4:0] S_DIV   = 5'd4;
  localparam logic [4:0] S_T_FIN = 5'd5;
  localparam logic [4:0] S_P_B6  = 5'd6;
  localparam logic [4:0] S_P_SQ  = 5'd7;
  localparam logic [4:0] S_P_M1  = 5'd8;
  localparam logic [4:0] S_P_M2  = 5'd9;
  localparam logic [4:0] S_P_M3  = 5'd10;
  localparam logic [4:0] S_P_M4  = 5'd11;
  localparam logic [4:0] S_P_M5  = 5'd12;
  localparam logic [4:0] S_P_M6  = 5'd13;
  localparam logic [4:0] S_P_M7  = 5'd14;
  localparam logic [4:0] S_P_M8  = 5'd15;
  localparam logic [4:0] S_P_CHK = 5'd16;
  localparam logic [4:0] S_P_P   = 5'd17;
  localparam logic [4:0] S_P_H   = 5'd18;
  localparam logic [4:0] S_P_HH  = 5'd19;
  localparam logic [4:0] S_P_X1  = 5'd20;
  localparam logic [4:0] S_P_FIN = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  logic [47:0] ac123_q, ac456_q;
  logic [31:0] b12_q, mcmd_q;
  logic [1:0]  oss_q;
  logic [31:0] b5_q, b5_d;

  logic [4:0]  state_q, state_d;
  logic        kind_q;
  logic [23:0] raw_q;
  logic [31:0] prod_q, mul_a, mul_b, prod_w;
  logic [31:0] prod_sh11, prod_sh16;
  logic [31:0] x1_q, x1_d, b6_q, b6_d, sq_q, sq_d, acc_q, acc_d;
  logic [31:0] b3_q, b3_d, b4_q, b4_d, b7_q, b7_d, p_q, p_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [31:0] res_val_q, res_val_d;
  logic        res_flt_q, res_flt_d;
  logic        out_load;

  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] up, scale, tden, tnum, b3_sum, b3_sh, x3b, x2t, b5_new, t_sh;
  logic [32:0] rem_sh;

  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      bcu_pkg::REG_AC123: prdata = {16'd0, ac123_q};
      bcu_pkg::REG_AC456: prdata = {16'd0, ac456_q};
      bcu_pkg::REG_B12:   prdata = {32'd0, b12_q};
      bcu_pkg::REG_MCMD:  prdata = {32'd0, mcmd_q};
      bcu_pkg::REG_OSS:   prdata = {62'd0, oss_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac123_q <= '0;
      ac456_q <= '0;
      b12_q   <= '0;
      mcmd_q  <= '0;
      oss_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bcu_pkg::REG_AC123: ac123_q <= pwdata[47:0];
        bcu_pkg::REG_AC456: ac456_q <= pwdata[47:0];
        bcu_pkg::REG_B12:   b12_q   <= pwdata[31:0];
        bcu_pkg::REG_MCMD:  mcmd_q  <= pwdata[31:0];
        bcu_pkg::REG_OSS:   oss_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  assign ac1 = {{16{ac123_q[47]}}, ac123_q[47:32]};
  assign ac2 = {{16{ac123_q[31]}}, ac123_q[31:16]};
  assign ac3 = {{16{ac123_q[15]}}, ac123_q[15:0]};
  assign ac4 = {16'd0, ac456_q[47:32]};
  assign ac5 = {16'd0, ac456_q[31:16]};
  assign ac6 = {16'd0, ac456_q[15:0]};
  assign b1  = {{16{b12_q[31]}}, b12_q[31:16]};
  assign b2  = {{16{b12_q[15]}}, b12_q[15:0]};
  assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
  assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

  assign prod_sh11 = $signed(prod_q) >>> 11;
  assign prod_sh16 = $signed(prod_q) >>> 16;

  assign up    = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
  assign scale = bcu_pkg::P_SCALE >> oss_q;
  assign tden  = x1_q + md;
  assign tnum  = mc << 11;
  assign b3_sum = ((ac1 << 2) + acc_q) << oss_q;
  assign b3_sh  = b3_sum + 32'd2;
  assign x3b    = acc_q + prod_sh16 + 32'd2;
  assign x2t    = neg_q ? (32'd0 - quo_q) : quo_q;
  assign b5_new = x1_q + x2t;
  assign t_sh   = $signed(b5_new + 32'd8) >>> 4;
  assign rem_sh = {rem_q, quo_q[31]};

  always_comb begin
    unique case (state_q)
      S_T_MUL: begin mul_a = {16'd0, raw_q[15:0]} - ac6; mul_b = ac5; end
      S_P_SQ:  begin mul_a = b6_q;                       mul_b = b6_q; end
      S_P_M1:  begin mul_a = ac2;                        mul_b = b6_q; end
      S_P_M2:  begin mul_a = b2;                         mul_b = sq_q; end
      S_P_M3:  begin mul_a = ac3;                        mul_b = b6_q; end
      S_P_M4:  begin mul_a = b1;                         mul_b = sq_q; end
      S_P_M6:  begin mul_a = ac4;                        mul_b = acc_q + 32'd32768; end
      S_P_M7:  begin mul_a = up - b3_q;                  mul_b = scale; end
      S_P_H:   begin mul_a = $signed(p_q) >>> 8;         mul_b = $signed(p_q) >>> 8; end
      S_P_HH:  begin mul_a = prod_q;                     mul_b = bcu_pkg::P_C1; end
      S_P_X1:  begin mul_a = bcu_pkg::P_C2_NEG;          mul_b = p_q; end
      default: begin mul_a = '0;                         mul_b = '0; end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  always_comb begin
    state_d   = state_q;
    b5_d      = b5_q;
    x1_d      = x1_q;
    b6_d      = b6_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    b3_d      = b3_q;
    b4_d      = b4_q;
    b7_d      = b7_q;
    p_d       = p_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    den_d     = den_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    res_val_d = res_val_q;
    res_flt_d = res_flt_q;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (operation_i == bcu_pkg::OP_PRESS) ? S_P_B6 : S_T_MUL;
        end
      end
      S_T_MUL: state_d = S_T_X1;
      S_T_X1: begin
        x1_d    = $signed(prod_q) >>> 15;
        state_d = S_T_CHK;
      end
      S_T_CHK: begin
        if (tden == '0) begin
          res_val_d = '0;
          res_flt_d = 1'b1;
          state_d   = S_OUT;
        end else begin
          rem_d   = '0;
          quo_d   = tnum[31] ? (32'd0 - tnum) : tnum;
          den_d   = tden[31] ? (32'd0 - tden) : tden;
          neg_d   = tnum[31] ^ tden[31];
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = 32'(rem_sh - {1'b0, den_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = (kind_q == bcu_pkg::OP_PRESS) ? S_P_P : S_T_FIN;
        end
      end
      S_T_FIN: begin
        b5_d      = b5_new;
        res_val_d = {{16{t_sh[15]}}, t_sh[15:0]};
        res_flt_d = 1'b0;
        state_d   = S_OUT;
      end
      S_P_B6: begin
        b6_d    = b5_q - bcu_pkg::B6_OFFSET;
        state_d = S_P_SQ;
      end
      S_P_SQ: state_d = S_P_M1;
      S_P_M1: begin
        sq_d    = $signed(prod_q) >>> 12;
        state_d = S_P_M2;
      end
      S_P_M2: begin
        acc_d   = $signed(prod_q) >>> 11;
        state_d = S_P_M3;
      end
      S_P_M3: begin
        acc_d   = acc_q + prod_sh11;
        state_d = S_P_M4;
      end
      S_P_M4: begin
        b3_d    = $signed(b3_sh) >>> 2;
        acc_d   = $signed(prod_q) >>> 13;
        state_d = S_P_M5;
      end
      S_P_M5: begin
        acc_d   = $signed(x3b) >>> 2;
        state_d = S_P_M6;
      end
      S_P_M6: state_d = S_P_M7;
      S_P_M7: begin
        b4_d    = prod_q >> 15;
        state_d = S_P_M8;
      end
      S_P_M8: begin
        b7_d    = prod_q;
        state_d = S_P_CHK;
      end
      S_P_CHK: begin
        if (b4_q == '0) begin
          res_val_d = '0;
          res_flt_d = 1'b1;
          state_d   = S_OUT;
        end else begin
          rem_d   = '0;
          quo_d   = (b7_q < bcu_pkg::P_HALF) ? (b7_q << 1) : b7_q;
          den_d   = b4_q;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_P_P: begin
        p_d     = (b7_q < bcu_pkg::P_HALF) ? quo_q : (quo_q << 1);
        state_d = S_P_H;
      end
      S_P_H:  state_d = S_P_HH;
      S_P_HH: state_d = S_P_X1;
      S_P_X1: begin
        acc_d   = $signed(prod_q) >>> 16;
        state_d = S_P_FIN;
      end
      S_P_FIN: begin
        res_val_d = p_q + 32'($signed(acc_q + prod_sh16 + bcu_pkg::P_C3) >>> 4);
        res_flt_d = 1'b0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      b5_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      b5_q    <= b5_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= operation_i;
      raw_q  <= raw_reading_i;
    end
    prod_q    <= prod_w;
    x1_q      <= x1_d;
    b6_q      <= b6_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    b3_q      <= b3_d;
    b4_q      <= b4_d;
    b7_q      <= b7_d;
    p_q       <= p_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    res_val_q <= res_val_d;
    res_flt_q <= res_flt_d;
    if (out_load) begin
      result_kind_o       <= kind_q;
      compensated_value_o <= res_val_q;
      divide_fault_o      <= res_flt_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bcu_checker.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation checker
// Port-level checks of item flow and result encoding, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "barometer_compensation_unit_macros.svh"
module bcu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        result_kind_o,
  input wire logic [31:0] compensated_value_o,
  input wire logic        divide_fault_o
);

  `BCU_CHECK(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `BCU_CHECK(a_fault_zero, (out_valid_o && divide_fault_o) |-> (compensated_value_o == '0))
  `BCU_CHECK(a_temp_range, (out_valid_o && result_kind_o == bcu_pkg::OP_TEMP) |-> (compensated_value_o[31:15] == '0 || compensated_value_o[31:15] == '1))
  `BCU_CHECK(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(compensated_value_o)))

endmodule

bind barometer_compensation_unit bcu_checker u_bcu_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .result_kind_o      (result_kind_o),
  .compensated_value_o(compensated_value_o),
  .divide_fault_o     (divide_fault_o)
);
`default_nettype wire

// ===== sim/barometer_compensation_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation unit testbench
// Drives temperature and pressure readings through the valid/ready channel,
// programs calibration over APB between phases, and checks every result
// against an in-bench model of the compensation datapath or a table's fixed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module barometer_compensation_unit_tb;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned MaxErrShown = 10;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        fault;
  } comp_result_t;

  typedef struct {
    logic        op;
    logic [23:0] raw;
    logic        chk;
    logic [31:0] value;
    logic        fault;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bcu_pkg::AddrW-1:0] paddr = '0;
  logic [bcu_pkg::DataW-1:0] pwdata = '0;
  logic [bcu_pkg::DataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = 1'b0;
  logic [23:0] raw_reading_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic result_kind_o;
  logic signed [31:0] compensated_value_o;
  logic divide_fault_o;

  logic [47:0] cal_ac123, cal_ac456;
  logic [31:0] cal_b12, cal_mcmd, b5_term;
  logic [1:0]  oss_sel;

  comp_result_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  bit drain_on = 1'b0;

  barometer_compensation_unit dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] quot_s(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(logic op, logic [23:0] raw);
    comp_result_t r;
    logic [31:0] ut, x1, x2, x3, den, b5, t, up, b6, sq, b3, b4, b7, p, h;
    r.kind = op;
    r.value = '0;
    r.fault = 1'b0;
    if (op == bcu_pkg::OP_TEMP) begin
      ut = {16'd0, raw[15:0]};
      x1 = asr32((ut - {16'd0, cal_ac456[15:0]}) * {16'd0, cal_ac456[31:16]}, 15);
      den = x1 + sx16(cal_mcmd[15:0]);
      if (den == 0) begin
        r.fault = 1'b1;
      end else begin
        x2 = quot_s(sx16(cal_mcmd[31:16]) << 11, den);
        b5 = x1 + x2;
        t = asr32(b5 + 32'd8, 4);
        b5_term = b5;
        r.value = sx16(t[15:0]);
      end
    end else begin
      up = {8'd0, raw} >> (8 - oss_sel);
      b6 = b5_term - bcu_pkg::B6_OFFSET;
      sq = asr32(b6 * b6, 12);
      x1 = asr32(sx16(cal_b12[15:0]) * sq, 11);
      x2 = asr32(sx16(cal_ac123[31:16]) * b6, 11);
      x3 = x1 + x2;
      b3 = asr32(((sx16(cal_ac123[47:32]) * 32'd4 + x3) << oss_sel) + 32'd2, 2);
      x1 = asr32(sx16(cal_ac123[15:0]) * b6, 13);
      x2 = asr32(sx16(cal_b12[31:16]) * sq, 16);
      x3 = asr32(x1 + x2 + 32'd2, 2);
      b4 = ({16'd0, cal_ac456[47:32]} * (x3 + 32'd32768)) >> 15;
      b7 = (up - b3) * (bcu_pkg::P_SCALE >> oss_sel);
      if (b4 == 0) begin
        r.fault = 1'b1;
      end else begin
        p = (b7 < bcu_pkg::P_HALF) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
        h = asr32(p, 8);
        x1 = asr32((h * h) * bcu_pkg::P_C1, 16);
        x2 = asr32(bcu_pkg::P_C2_NEG * p, 16);
        r.value = p + asr32(x1 + x2 + bcu_pkg::P_C3, 4);
      end
    end
    return r;
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= bcu_pkg::AddrW'(idx) << 3;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bcu_pkg::REG_AC123: cal_ac123 = data[47:0];
      bcu_pkg::REG_AC456: cal_ac456 = data[47:0];
      bcu_pkg::REG_B12:   cal_b12 = data[31:0];
      bcu_pkg::REG_MCMD:  cal_mcmd = data[31:0];
      default:            oss_sel = data[1:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic program_cal(logic [47:0] a, logic [47:0] b, logic [31:0] c,
                             logic [31:0] d, logic [1:0] o);
    wait_drained();
    apb_write(bcu_pkg::REG_AC123, {16'd0, a});
    apb_write(bcu_pkg::REG_AC456, {16'd0, b});
    apb_write(bcu_pkg::REG_B12, {32'd0, c});
    apb_write(bcu_pkg::REG_MCMD, {32'd0, d});
    apb_write(bcu_pkg::REG_OSS, {62'd0, o});
  endtask

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send_reading(logic op, logic [23:0] raw, logic chk,
                              logic [31:0] val, logic flt, bit gaps);
    comp_result_t exp_r;
    @(negedge clk_i);
    if (gaps) repeat (gap_len()) @(negedge clk_i);
    exp_r = compensate(op, raw);
    if (chk && (exp_r.value !== val || exp_r.fault !== flt)) begin
      exp_r.value = val;
      exp_r.fault = flt;
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    raw_reading_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(exp_r);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    comp_result_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{result_kind_o, compensated_value_o, divide_fault_o};
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxErrShown)
          $display("unexpected result kind=%0d value=%0d fault=%0d",
                   got.kind, $signed(got.value), got.fault);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxErrShown)
            $display("mismatch: exp kind=%0d value=%0d fault=%0d, got kind=%0d value=%0d fault=%0d",
                     want.kind, $signed(want.value), want.fault,
                     got.kind, $signed(got.value), got.fault);
        end
      end
    end
  end

  int unsigned ready_hold = 0;
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!drain_on && $urandom_range(0, 3) == 0) begin
      ready_hold <= gap_len();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  stim_row_t stim_table[$];

  initial begin
    logic [23:0] raw;
    cal_ac123 = '0; cal_ac456 = '0; cal_b12 = '0; cal_mcmd = '0;
    oss_sel = '0; b5_term = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero calibration: temperature divisor zero, pressure divisor zero
    stim_table = '{
      '{bcu_pkg::OP_TEMP, 24'h000000, 1'b1, 32'd0, 1'b1},
      '{bcu_pkg::OP_PRESS, 24'hFFFFFF, 1'b1, 32'd0, 1'b1},
      '{bcu_pkg::OP_TEMP, 24'hFFFFFF, 1'b1, 32'd0, 1'b1}
    };
    foreach (stim_table[i])
      send_reading(stim_table[i].op, stim_table[i].raw, stim_table[i].chk,
                   stim_table[i].value, stim_table[i].fault, 1'b0);

    program_cal({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
                {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
    stim_table = '{
      '{bcu_pkg::OP_PRESS, 24'h5D23AB, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_TEMP, 24'hFF6C4A, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'h5D23AB, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_TEMP, 24'h000000, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_TEMP, 24'h00FFFF, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'h000000, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_TEMP, 24'h006C4A, 1'b0, 32'd0, 1'b0}
    };
    foreach (stim_table[i])
      send_reading(stim_table[i].op, stim_table[i].raw, 1'b0, 32'd0, 1'b0, 1'b1);

    program_cal({16'h7FFF, 16'h8000, 16'h7FFF}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
                {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000}, 2'd3);
    stim_table = '{
      '{bcu_pkg::OP_TEMP, 24'h00FFFF, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'hFFFFFF, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_TEMP, 24'h000001, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'h000000, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'hAAAAAA, 1'b0, 32'd0, 1'b0},
      '{bcu_pkg::OP_PRESS, 24'h555555, 1'b0, 32'd0, 1'b0}
    };
    foreach (stim_table[i])
      send_reading(stim_table[i].op, stim_table[i].raw, 1'b0, 32'd0, 1'b0, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0)
        program_cal({16'd408 + 16'($urandom_range(0, 400)) - 16'd200,
                     -16'sd72 + 16'($urandom_range(0, 100)) - 16'd50,
                     -16'sd14383 + 16'($urandom_range(0, 2000))},
                    {16'd32741 - 16'($urandom_range(0, 2000)),
                     16'd32757 - 16'($urandom_range(0, 2000)),
                     16'd23153 + 16'($urandom_range(0, 2000))},
                    {16'd6190 + 16'($urandom_range(0, 200)), 16'($urandom_range(0, 20))},
                    {-16'sd8711 + 16'($urandom_range(0, 200)),
                     16'd2868 + 16'($urandom_range(0, 200))},
                    2'(phase / 2));
      else
        program_cal({$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
                    $urandom, $urandom, 2'($urandom));
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          raw = 24'($urandom);
          if (phase % 2 == 0) raw[15:0] = 16'h6000 + 16'($urandom_range(0, 4095));
          send_reading(bcu_pkg::OP_TEMP, raw, 1'b0, 32'd0, 1'b0, 1'b1);
        end else begin
          raw = 24'($urandom);
          if (phase % 2 == 0) raw = 24'h5000_00 + 24'($urandom_range(0, 24'h1FFFFF));
          send_reading(bcu_pkg::OP_PRESS, raw, 1'b0, 32'd0, 1'b0, 1'b1);
        end
        if (k == 60 && phase == 3) wait_drained();
      end
    end

    drain_on = 1'b1;
    wait_drained();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
